/* rtl/vdi_pkg.sv */
// shared constants for the vertex dedup indexer
package vdi_pkg;

  // coordinate width, fixed by the point and average fields (Q8.8)
  localparam int COORD_BITS = 16;
  // width of one packed table entry (x, y, z)
  localparam int KEY_W = 3 * COORD_BITS;
  // width of the vertex_index field
  localparam int INDEX_OUT_W = 8;

  // parameter defaults
  localparam int MAX_VERTICES_DEF = 256;
  localparam int MAX_FACE_POINTS_DEF = 8;

endpackage

/* rtl/vertex_dedup_indexer_core.sv */
// Vertex dedup indexer: table search, append and per-face coordinate average
//
// Each point item searches the vertex table one entry per cycle through a
// registered memory read port, until a stored entry matches or every stored
// entry has been read. A point that closes a face also runs the shared
// restoring divider once per axis, one quotient bit per cycle, before its
// result is pushed. in_ready is high only between items; a finished result
// waits in the output register while the next item is accepted. Points with
// no match are appended; once the table holds MAX_VERTICES entries a new
// point is not stored, vertex_index reads MAX_VERTICES-1 and overflow is set.
// Points past MAX_FACE_POINTS in a face are indexed but not averaged.
module vertex_dedup_indexer_core
  import vdi_pkg::*;
#(
  parameter int MAX_VERTICES    = MAX_VERTICES_DEF,
  parameter int MAX_FACE_POINTS = MAX_FACE_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic signed [COORD_BITS-1:0]  point_z,
  input  logic                          last_of_face,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [INDEX_OUT_W-1:0]        vertex_index,
  output logic                          is_new,
  output logic                          overflow,
  output logic                          face_done,
  output logic signed [COORD_BITS-1:0]  avg_x,
  output logic signed [COORD_BITS-1:0]  avg_y,
  output logic signed [COORD_BITS-1:0]  avg_z
);

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int FP_W   = $clog2(MAX_FACE_POINTS + 1);
  localparam int SUM_W  = COORD_BITS + $clog2(MAX_FACE_POINTS);
  localparam int DCNT_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // control state
  logic [1:0]              state;
  logic [CNT_W-1:0]        vertex_count;
  logic [CNT_W-1:0]        scan_addr;
  logic                    rd_pending;
  logic [FP_W-1:0]         face_points;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [SUM_W-1:0] sum_z;
  logic [1:0]              div_axis;
  logic                    div_load;
  logic [DCNT_W-1:0]       div_cnt;

  // payload registers
  logic [KEY_W-1:0]        key;
  logic                    last_r;
  logic [IDX_W-1:0]        rd_addr;
  logic [KEY_W-1:0]        rd_data;
  logic [IDX_W-1:0]        idx_res;
  logic                    is_new_r;
  logic                    ovf_r;
  logic [SUM_W-1:0]        dvd;
  logic [FP_W-1:0]         rem;
  logic                    neg;
  logic [COORD_BITS-1:0]   avg_res_x;
  logic [COORD_BITS-1:0]   avg_res_y;
  logic [COORD_BITS-1:0]   avg_res_z;

  // vertex table
  logic [KEY_W-1:0]        vertex_store [MAX_VERTICES];

  // scan decisions
  logic hit;
  logic all_issued;
  logic miss;
  logic room;
  logic mem_we;
  logic in_fire;
  logic push_fire;

  // divider step
  logic signed [SUM_W-1:0] sum_sel;
  logic [SUM_W-1:0]        sum_mag;
  logic [FP_W:0]           rem_shift;
  logic                    q_bit;
  logic [SUM_W-1:0]        quot;
  logic [SUM_W-1:0]        quot_signed;
  logic                    div_last_step;

  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign hit        = rd_pending && (rd_data == key);
  assign all_issued = (scan_addr == vertex_count);
  assign miss       = !hit && all_issued;
  assign room       = (vertex_count < CNT_W'(MAX_VERTICES));
  assign mem_we     = (state == ST_SCAN) && miss && room;
  assign push_fire  = (state == ST_PUSH) && (!out_valid || out_ready);

  // sum selection for the current axis
  always_comb begin
    case (div_axis)
      AXIS_X:  sum_sel = sum_x;
      AXIS_Y:  sum_sel = sum_y;
      AXIS_Z:  sum_sel = sum_z;
      default: sum_sel = sum_x;
    endcase
  end

  assign sum_mag = sum_sel[SUM_W-1] ? (~sum_sel + SUM_W'(1)) : sum_sel;

  // one restoring division step
  assign rem_shift     = {rem, dvd[SUM_W-1]};
  assign q_bit         = (rem_shift >= {1'b0, face_points});
  assign quot          = {dvd[SUM_W-2:0], q_bit};
  assign quot_signed   = neg ? (~quot + SUM_W'(1)) : quot;
  assign div_last_step = (div_cnt == DCNT_W'(SUM_W - 1));

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      vertex_store[vertex_count[IDX_W-1:0]] <= key;
    end
    rd_data <= vertex_store[scan_addr[IDX_W-1:0]];
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= '0;
      scan_addr    <= '0;
      rd_pending   <= 1'b0;
      face_points  <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_z        <= '0;
      div_axis     <= AXIS_X;
      div_load     <= 1'b0;
      div_cnt      <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (push_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            scan_addr  <= '0;
            rd_pending <= 1'b0;
            state      <= ST_SCAN;
            if (face_points < FP_W'(MAX_FACE_POINTS)) begin
              sum_x       <= sum_x + SUM_W'(point_x);
              sum_y       <= sum_y + SUM_W'(point_y);
              sum_z       <= sum_z + SUM_W'(point_z);
              face_points <= face_points + FP_W'(1);
            end
          end
        end
        ST_SCAN: begin
          if (hit || miss) begin
            rd_pending <= 1'b0;
            div_axis   <= AXIS_X;
            div_load   <= 1'b1;
            state      <= last_r ? ST_DIV : ST_PUSH;
            if (mem_we) begin
              vertex_count <= vertex_count + CNT_W'(1);
            end
          end else begin
            rd_pending <= 1'b1;
            scan_addr  <= scan_addr + CNT_W'(1);
          end
        end
        ST_DIV: begin
          if (div_load) begin
            div_load <= 1'b0;
            div_cnt  <= '0;
          end else begin
            div_cnt <= div_cnt + DCNT_W'(1);
            if (div_last_step) begin
              if (div_axis == AXIS_Z) begin
                state <= ST_PUSH;
              end else begin
                div_axis <= div_axis + 2'd1;
                div_load <= 1'b1;
              end
            end
          end
        end
        ST_PUSH: begin
          if (push_fire) begin
            state <= ST_IDLE;
            if (last_r) begin
              sum_x       <= '0;
              sum_y       <= '0;
              sum_z       <= '0;
              face_points <= '0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key    <= {point_z, point_y, point_x};
      last_r <= last_of_face;
    end

    if (state == ST_SCAN && !all_issued && !hit) begin
      rd_addr <= scan_addr[IDX_W-1:0];
    end

    if (state == ST_SCAN && (hit || miss)) begin
      is_new_r <= miss && room;
      ovf_r    <= miss && !room;
      if (hit) begin
        idx_res <= rd_addr;
      end else if (room) begin
        idx_res <= vertex_count[IDX_W-1:0];
      end else begin
        idx_res <= IDX_W'(MAX_VERTICES - 1);
      end
    end

    if (state == ST_DIV) begin
      if (div_load) begin
        dvd <= sum_mag;
        rem <= '0;
        neg <= sum_sel[SUM_W-1];
      end else begin
        dvd <= quot;
        rem <= q_bit ? FP_W'(rem_shift - {1'b0, face_points}) : FP_W'(rem_shift);
        if (div_last_step) begin
          case (div_axis)
            AXIS_X:  avg_res_x <= quot_signed[COORD_BITS-1:0];
            AXIS_Y:  avg_res_y <= quot_signed[COORD_BITS-1:0];
            AXIS_Z:  avg_res_z <= quot_signed[COORD_BITS-1:0];
            default: avg_res_x <= quot_signed[COORD_BITS-1:0];
          endcase
        end
      end
    end

    if (push_fire) begin
      vertex_index <= INDEX_OUT_W'(idx_res);
      is_new       <= is_new_r;
      overflow     <= ovf_r;
      face_done    <= last_r;
      avg_x        <= last_r ? avg_res_x : '0;
      avg_y        <= last_r ? avg_res_y : '0;
      avg_z        <= last_r ? avg_res_z : '0;
    end
  end

`ifndef NO_ASSERTIONS
  // table never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    vertex_count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above table depth");

  // face point count stays within its limit
  a_face_bound: assert property (@(posedge clk) disable iff (rst)
    face_points <= FP_W'(MAX_FACE_POINTS))
    else $error("face point count above limit");

  // an append grows the table by exactly one
  a_append: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> vertex_count == $past(vertex_count) + CNT_W'(1))
    else $error("append did not advance vertex count");

  // a result is never both new and overflowed
  a_new_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(is_new && overflow))
    else $error("is_new and overflow both set");

  // averages read zero when no face ends
  a_avg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !face_done) |-> (avg_x == '0 && avg_y == '0 && avg_z == '0))
    else $error("average fields nonzero without face end");
`endif

endmodule

/* verif/vertex_dedup_indexer_core_test.sv */
// vertex dedup indexer core bench: directed, random faces checked against a predicted table
module vertex_dedup_indexer_core_test
  import vdi_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_VERTICES   = MAX_VERTICES_DEF;
  localparam int FACE_POINT_CAP = MAX_FACE_POINTS_DEF;
  localparam int RANDOM_ITEMS   = 500;
  localparam int DRAIN_CYCLES   = 400;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0]        vertex_index;
    logic                          is_new;
    logic                          overflow;
    logic                          face_done;
    logic signed [COORD_BITS-1:0]  avg_x;
    logic signed [COORD_BITS-1:0]  avg_y;
    logic signed [COORD_BITS-1:0]  avg_z;
  } vertex_result_t;

  // mirrors the vertex table and face sums, checks each result item in order
  class vertex_index_scoreboard;
    logic [KEY_W-1:0] known_vertices [NUM_VERTICES];
    int               stored_count;
    int               face_sum_x;
    int               face_sum_y;
    int               face_sum_z;
    int               face_count;
    vertex_result_t   awaited_results [$];
    int               mismatches;

    function new();
      stored_count = 0;
      face_sum_x   = 0;
      face_sum_y   = 0;
      face_sum_z   = 0;
      face_count   = 0;
      mismatches   = 0;
    endfunction

    // search, append, accumulate, and queue the predicted result
    function void note_point(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y,
                             logic signed [COORD_BITS-1:0] z, logic last);
      vertex_result_t r;
      logic [KEY_W-1:0] key;
      int idx;
      int q;
      key = {z, y, x};
      r   = '0;
      idx = 0;
      while (idx < stored_count && known_vertices[idx] != key) idx++;
      if (idx == stored_count) begin
        if (stored_count < NUM_VERTICES) begin
          known_vertices[stored_count] = key;
          stored_count++;
          r.is_new = 1'b1;
        end else begin
          // table full: index saturates
          idx        = NUM_VERTICES - 1;
          r.overflow = 1'b1;
        end
      end
      r.vertex_index = idx[INDEX_OUT_W-1:0];
      // points past the face cap are indexed only
      if (face_count < FACE_POINT_CAP) begin
        face_sum_x += x;
        face_sum_y += y;
        face_sum_z += z;
        face_count++;
      end
      if (last) begin
        r.face_done = 1'b1;
        q = face_sum_x / face_count;
        r.avg_x = q[COORD_BITS-1:0];
        q = face_sum_y / face_count;
        r.avg_y = q[COORD_BITS-1:0];
        q = face_sum_z / face_count;
        r.avg_z = q[COORD_BITS-1:0];
        face_sum_x = 0;
        face_sum_y = 0;
        face_sum_z = 0;
        face_count = 0;
      end
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s expected %0d actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(vertex_result_t got);
      vertex_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result item with no point waiting for it");
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("vertex_index", want.vertex_index, got.vertex_index);
      compare_field("is_new", want.is_new, got.is_new);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("face_done", want.face_done, got.face_done);
      compare_field("avg_x", want.avg_x, got.avg_x);
      compare_field("avg_y", want.avg_y, got.avg_y);
      compare_field("avg_z", want.avg_z, got.avg_z);
    endfunction

    function int outstanding();
      return awaited_results.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [COORD_BITS-1:0]  point_x = '0;
  logic signed [COORD_BITS-1:0]  point_y = '0;
  logic signed [COORD_BITS-1:0]  point_z = '0;
  logic                          last_of_face = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [INDEX_OUT_W-1:0]        vertex_index;
  logic                          is_new;
  logic                          overflow;
  logic                          face_done;
  logic signed [COORD_BITS-1:0]  avg_x;
  logic signed [COORD_BITS-1:0]  avg_y;
  logic signed [COORD_BITS-1:0]  avg_z;

  int send_idle_pct = 13;
  int recv_idle_pct = 59;
  logic [KEY_W-1:0] sent_points [$];
  vertex_index_scoreboard sb = new();

  vertex_dedup_indexer_core #(
    .MAX_VERTICES    (NUM_VERTICES),
    .MAX_FACE_POINTS (FACE_POINT_CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .point_z      (point_z),
    .last_of_face (last_of_face),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_index (vertex_index),
    .is_new       (is_new),
    .overflow     (overflow),
    .face_done    (face_done),
    .avg_x        (avg_x),
    .avg_y        (avg_y),
    .avg_z        (avg_z)
  );

  always #10 clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watch both handshakes
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_result({vertex_index, is_new, overflow, face_done, avg_x, avg_y, avg_z});
      end
      if (in_valid && in_ready) begin
        sb.note_point(point_x, point_y, point_z, last_of_face);
      end
    end
  end

  // present one point item and hold it until accepted
  task automatic send_point(input logic signed [COORD_BITS-1:0] x,
                            input logic signed [COORD_BITS-1:0] y,
                            input logic signed [COORD_BITS-1:0] z, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    point_x      <= x;
    point_y      <= y;
    point_z      <= z;
    last_of_face <= last;
    sent_points.insert(sent_points.size(), {z, y, x});
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // coordinate with a bias toward the range ends, zero and minus one
  function automatic logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 15))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return COORD_BITS'($urandom());
    endcase
  endfunction

  // one face of random points, some repeating earlier points
  task automatic send_random_face(input int npts);
    logic [KEY_W-1:0] p;
    for (int i = 0; i < npts; i++) begin
      if (sent_points.size() > 0 && $urandom_range(0, 99) < 30) begin
        p = sent_points[$urandom_range(0, sent_points.size() - 1)];
      end else begin
        p = {pick_coord(), pick_coord(), pick_coord()};
      end
      send_point(p[COORD_BITS-1:0], p[2*COORD_BITS-1:COORD_BITS], p[KEY_W-1:2*COORD_BITS],
                 i == npts - 1);
    end
  endtask

  // run time limit
  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int sent;
    int npts;
    int r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-point faces: new vertex, then a match
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    // range extremes in one face
    send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd1, -16'sd1, 16'sh0100, 1'b1);
    // negative average truncates toward zero
    send_point(-16'sd1, -16'sd1, -16'sd3, 1'b0);
    send_point(16'sd0, 16'sd0, 16'sd0, 1'b1);
    // face longer than the cap: the tail points are not averaged
    for (int i = 1; i <= 10; i++) begin
      send_point(16'(i * 256), -16'(i * 256), 16'(i), i == 10);
    end
    // full face at the positive limit
    for (int i = 0; i < FACE_POINT_CAP; i++) begin
      send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, i == FACE_POINT_CAP - 1);
    end

    // random faces in three idling phases
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent >= RANDOM_ITEMS / 3) begin
        send_idle_pct = 59;
        recv_idle_pct = 13;
      end
      r = $urandom_range(0, 99);
      if (r < 80) npts = $urandom_range(3, FACE_POINT_CAP);
      else if (r < 90) npts = $urandom_range(1, 2);
      else npts = $urandom_range(FACE_POINT_CAP + 1, FACE_POINT_CAP + 6);
      send_random_face(npts);
      sent += npts;
    end
    in_valid <= 1'b0;

    // drain
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
